// ===== design/esa_pkg.sv =====
// Shared widths, constants and control structs of the encoder speed averager.
package esa_pkg;

	localparam int COUNT_W        = 16;
	localparam int TIME_W         = 32;
	localparam int PERIOD_W       = 16;
	localparam int SPEED_W        = 20;
	localparam int SCALED_W       = 26;
	localparam int DVD_W          = 26;
	localparam int RATE_SCALE     = 1000;
	localparam int SPEED_LIMIT    = 327680;
	localparam int PERIOD_RESET   = 100;
	localparam int WINDOW_DEFAULT = 8;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic check;
		logic prime;
		logic rate_start;
		logic ring;
		logic avg;
		logic out_load;
	} esa_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic primed;
		logic due;
		logic div_done;
	} esa_sts_t;

endpackage

// ===== design/encoder_speed_averager.sv =====
// Top level of the encoder speed averager: controller, datapath and configuration port.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | in_valid / in_stall  | encoder_count[15:0], now_ms[31:0]
//   result   | out_valid / out_stall| speed[19:0] signed, updated
//   config   | cfg_valid / cfg_ready| sample_period_ms[15:0]
//
// An item that only sets the baseline or takes no sample passes through the check and finish steps only.
// A sampling item makes one pass through the serial divider for count delta by elapsed
// time; the average is a multiply.
// Reset clears baseline, history valid bits, running sum and average; no clearing pass.
// A new item is taken while the last result waits; a stalled result only holds the finish step.
module encoder_speed_averager #(
	parameter int WINDOW = esa_pkg::WINDOW_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [esa_pkg::COUNT_W-1:0]         encoder_count,
	input  logic [esa_pkg::TIME_W-1:0]          now_ms,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [esa_pkg::SPEED_W-1:0]  speed,
	output logic                                updated,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [esa_pkg::PERIOD_W-1:0]        sample_period_ms
);

	esa_pkg::esa_cmd_t cmd;
	esa_pkg::esa_sts_t sts;
	logic              cfg_wr;

	// Configuration writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	esa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	esa_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_wr        (cfg_wr),
		.cfg_data      (sample_period_ms),
		.encoder_count (encoder_count),
		.now_ms        (now_ms),
		.speed         (speed),
		.updated       (updated)
	);

endmodule

// ===== design/esa_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module esa_div #(
	parameter int DVD_W = esa_pkg::DVD_W,
	parameter int DSR_W = esa_pkg::TIME_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DSR_W-1:0] dsr_q;
	logic [DSR_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DSR_W:0]   shifted;
	logic [DSR_W:0]   diff;
	logic             ge;

	// Trial subtraction of the shifted partial remainder
	always_comb begin
		shifted = {rem_q, dvd_q[DVD_W-1]};
		diff    = shifted - {1'b0, dsr_q};
		ge      = (shifted >= {1'b0, dsr_q});
	end

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift the quotient in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== design/esa_dp.sv =====
// Datapath: baseline, rate scaling, history ring, running sum and output register.
module esa_dp #(
	parameter int WINDOW = esa_pkg::WINDOW_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  esa_pkg::esa_cmd_t                   cmd,
	output esa_pkg::esa_sts_t                   sts,
	input  logic                                cfg_wr,
	input  logic [esa_pkg::PERIOD_W-1:0]        cfg_data,
	input  logic [esa_pkg::COUNT_W-1:0]         encoder_count,
	input  logic [esa_pkg::TIME_W-1:0]          now_ms,
	output logic signed [esa_pkg::SPEED_W-1:0]  speed,
	output logic                                updated
);

	localparam int SPEED_W  = esa_pkg::SPEED_W;
	localparam int SCALED_W = esa_pkg::SCALED_W;
	localparam int DVD_W    = esa_pkg::DVD_W;
	localparam int TIME_W   = esa_pkg::TIME_W;
	localparam int COUNT_W  = esa_pkg::COUNT_W;
	localparam int PERIOD_W = esa_pkg::PERIOD_W;
	localparam int SUM_W    = SPEED_W + $clog2(WINDOW);
	localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int RCP_SH   = SUM_W - 1 + $clog2(WINDOW);
	localparam int RCP_W    = RCP_SH + 1;
	localparam int PROD_W   = SUM_W + RCP_W;
	localparam longint unsigned RCP =
		((64'd1 << RCP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

	logic [PERIOD_W-1:0]        period_q;
	logic [COUNT_W-1:0]         count_q;
	logic [TIME_W-1:0]          now_q;
	logic [COUNT_W-1:0]         base_count_q;
	logic [TIME_W-1:0]          base_time_q;
	logic                       primed_q;
	logic [TIME_W-1:0]          dt_q;
	logic signed [SCALED_W-1:0] scaled_q;
	logic [SLOT_W-1:0]          slot_q;
	logic [WINDOW-1:0]          hist_vld_q;
	logic signed [SPEED_W-1:0]  hist_mem [WINDOW];
	logic signed [SPEED_W-1:0]  old_q;
	logic                       old_vld_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SPEED_W-1:0]  avg_q;
	logic                       upd_q;
	logic signed [SPEED_W-1:0]  speed_q;
	logic                       updated_q;

	logic [TIME_W-1:0]          dt;
	logic [TIME_W-1:0]          period_eff;
	logic [COUNT_W-1:0]         diff;
	logic signed [SCALED_W-1:0] delta_ext;
	logic signed [SCALED_W-1:0] scaled;
	logic [DVD_W-1:0]           rate_mag;
	logic [SUM_W-1:0]           sum_mag;
	logic [PROD_W-1:0]          avg_prod;
	logic [SPEED_W-1:0]         avg_mag;
	logic [DVD_W-1:0]           div_dvd;
	logic [TIME_W-1:0]          div_dsr;
	logic                       div_start;
	logic                       div_done;
	logic [DVD_W-1:0]           div_q;
	logic [SPEED_W-1:0]         sat_mag;
	logic signed [SPEED_W-1:0]  raw;
	logic signed [SPEED_W-1:0]  old_val;
	logic signed [SUM_W-1:0]    sum_next;

	// Elapsed time, due test and scaled count delta
	always_comb begin
		dt         = now_q - base_time_q;
		period_eff = (period_q == '0) ? TIME_W'(1) : TIME_W'(period_q);
		diff       = count_q - base_count_q;
		delta_ext  = SCALED_W'($signed(diff));
		scaled     = delta_ext * $signed(SCALED_W'(esa_pkg::RATE_SCALE));
	end

	// Magnitude of the scaled delta for the serial divider
	always_comb begin
		rate_mag = scaled_q[SCALED_W-1] ? DVD_W'($unsigned(-scaled_q))
		                                : DVD_W'($unsigned(scaled_q));
		div_start = cmd.rate_start;
		div_dvd   = rate_mag;
		div_dsr   = dt_q;
	end

	// Average by reciprocal multiply, exact over the whole running sum range
	always_comb begin
		sum_mag  = sum_q[SUM_W-1] ? $unsigned(-sum_q) : $unsigned(sum_q);
		avg_prod = PROD_W'(sum_mag) * PROD_W'(RCP_W'(RCP));
		avg_mag  = avg_prod[RCP_SH +: SPEED_W];
	end

	esa_div #(
		.DVD_W (DVD_W),
		.DSR_W (TIME_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (div_q)
	);

	// Saturate the raw rate and update the running sum
	always_comb begin
		sat_mag  = (div_q > DVD_W'(esa_pkg::SPEED_LIMIT)) ? SPEED_W'(esa_pkg::SPEED_LIMIT)
		                                                   : div_q[SPEED_W-1:0];
		raw      = scaled_q[SCALED_W-1] ? -$signed(sat_mag) : $signed(sat_mag);
		old_val  = old_vld_q ? old_q : '0;
		sum_next = sum_q + SUM_W'(raw) - SUM_W'(old_val);
	end

	// Control and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q     <= PERIOD_W'(esa_pkg::PERIOD_RESET);
			base_count_q <= '0;
			base_time_q  <= '0;
			primed_q     <= 1'b0;
			slot_q       <= '0;
			hist_vld_q   <= '0;
			sum_q        <= '0;
			avg_q        <= '0;
		end else begin
			if (cfg_wr) begin
				period_q <= cfg_data;
			end
			if (cmd.prime || cmd.ring) begin
				base_count_q <= count_q;
				base_time_q  <= now_q;
				primed_q     <= 1'b1;
			end
			if (cmd.ring) begin
				hist_vld_q[slot_q] <= 1'b1;
				sum_q              <= sum_next;
				slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			end
			if (cmd.avg) begin
				avg_q <= sum_q[SUM_W-1] ? -$signed(avg_mag) : $signed(avg_mag);
			end
		end
	end

	// Payload registers and history memory
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			count_q <= encoder_count;
			now_q   <= now_ms;
			upd_q   <= 1'b0;
		end
		if (cmd.check) begin
			dt_q      <= dt;
			scaled_q  <= scaled;
			old_q     <= hist_mem[slot_q];
			old_vld_q <= hist_vld_q[slot_q];
		end
		if (cmd.ring) begin
			hist_mem[slot_q] <= raw;
			upd_q            <= 1'b1;
		end
		if (cmd.out_load) begin
			speed_q   <= avg_q;
			updated_q <= upd_q;
		end
	end

	assign sts.primed   = primed_q;
	assign sts.due      = (dt >= period_eff);
	assign sts.div_done = div_done;
	assign speed        = speed_q;
	assign updated      = updated_q;

endmodule

// ===== design/esa_ctrl.sv =====
// Controller: sequences one item through check, rate division, ring update and averaging.
module esa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output esa_pkg::esa_cmd_t cmd,
	input  esa_pkg::esa_sts_t sts
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV1_GO,
		ST_DIV1_WAIT,
		ST_RING,
		ST_AVG,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	// Decode commands from the state
	always_comb begin
		cmd            = '0;
		cmd.capture    = (state_q == ST_IDLE) && in_valid;
		cmd.check      = (state_q == ST_CHECK);
		cmd.prime      = (state_q == ST_CHECK) && !sts.primed;
		cmd.rate_start = (state_q == ST_DIV1_GO);
		cmd.ring       = (state_q == ST_RING);
		cmd.avg        = (state_q == ST_AVG);
		cmd.out_load   = (state_q == ST_FINISH) && out_free;
	end

	// Hold state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (sts.primed && sts.due) begin
						state_q <= ST_DIV1_GO;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_DIV1_GO: begin
					state_q <= ST_DIV1_WAIT;
				end
				ST_DIV1_WAIT: begin
					if (sts.div_done) begin
						state_q <= ST_RING;
					end
				end
				ST_RING: begin
					state_q <= ST_AVG;
				end
				ST_AVG: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// A divider result only arrives while a division is awaited
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_DIV1_WAIT))
		else $error("divider done outside a wait state");

	// Never overwrite a result that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while stalled");

	// An accepted transaction goes straight to the check step
	a_accept_check: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_CHECK))
		else $error("accepted transaction not checked");

	// Each finished item raises the output valid
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");

endmodule
